/* rtl/fbpa_pkg.sv */
package fbpa_pkg;

   // operation codes of the request channel
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_SWEEP   = 2'd2;

   // commands broadcast along the row of slot cells
   localparam logic [1:0] CELL_IDLE  = 2'd0;
   localparam logic [1:0] CELL_CLAIM = 2'd1;
   localparam logic [1:0] CELL_FREE  = 2'd2;
   localparam logic [1:0] CELL_SWEEP = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_BLOCK_SIZE   = 3'd0;
   localparam logic [2:0] CSR_BLOCKS_USED  = 3'd1;
   localparam logic [2:0] CSR_MAX_AGE      = 3'd2;
   localparam logic [2:0] CSR_AUTO_SWEEP   = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD    = 3'd4;
   localparam logic [2:0] CSR_INTERVAL     = 3'd5;

   // configuration reset values
   localparam logic [20:0] RST_BLOCK_SIZE  = 21'd4096;
   localparam logic [6:0]  RST_BLOCKS_USED = 7'd8;
   localparam logic [31:0] RST_MAX_AGE     = 32'd300000;
   localparam logic        RST_AUTO_SWEEP  = 1'b1;
   localparam logic [6:0]  RST_THRESHOLD   = 7'd75;
   localparam logic [31:0] RST_INTERVAL    = 32'd30000;

   // percent scale for the utilization compare
   localparam logic [13:0] PCT_SCALE = 14'd100;

   // command and operands seen by every cell in the same cycle
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] tag;
      logic [31:0] match_id;
      logic [31:0] now;
      logic [31:0] age_limit;
   } cell_cmd_type;

   // per-cell status returned to the sequencer
   typedef struct packed {
      logic taken;
      logic grant;
      logic freed;
   } cell_stat_type;

endpackage

/* rtl/fixed_block_pool_allocator_top.sv */
// The idle step latches a request; in the execute step the slot row claims, releases or
// sweeps, the stats step recounts used slots, and the done step loads the response. An
// automatic sweep adds a sweep step and another stats step. Only idle takes requests.
// A stalled response holds the sequencer in its final step until the beat is taken.
// Reset (synchronous, active high): all slots free, next ID 1, counters and last sweep
// time 0, configuration registers at their documented defaults.
module fixed_block_pool_allocator_top #(
   parameter int BLOCK_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [20:0] req_request_size,
   input  logic [31:0] req_release_id,
   input  logic [31:0] req_now_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [5:0]  rsp_block_index,
   output logic [25:0] rsp_buffer_offset,
   output logic [20:0] rsp_granted_size,
   output logic [31:0] rsp_allocation_id,
   output logic [6:0]  rsp_blocks_freed,
   output logic [6:0]  rsp_used_blocks,
   output logic [6:0]  rsp_peak_used,
   output logic [31:0] rsp_allocation_total,
   output logic [31:0] rsp_release_total,
   output logic [31:0] rsp_failure_total,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import fbpa_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_STATS = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [6:0] SLOTS_W = 7'(BLOCK_SLOTS);

   // sequencer and bookkeeping
   logic [2:0]  state_ff, state_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [6:0]  used_ff, used_in;
   logic [6:0]  peak_ff, peak_in;
   logic [31:0] alloc_cnt_ff, alloc_cnt_in;
   logic [31:0] rel_cnt_ff, rel_cnt_in;
   logic [31:0] fail_cnt_ff, fail_cnt_in;
   logic [31:0] last_sweep_ff, last_sweep_in;
   logic        upd_ff, upd_in;
   logic        swept_ff, swept_in;

   // configuration
   logic [20:0] block_size_ff, block_size_in;
   logic [6:0]  blocks_used_ff, blocks_used_in;
   logic [31:0] max_age_ff, max_age_in;
   logic        auto_en_ff, auto_en_in;
   logic [6:0]  thresh_ff, thresh_in;
   logic [31:0] interval_ff, interval_in;

   // latched request
   logic [1:0]  op_ff, op_in;
   logic [20:0] size_ff, size_in;
   logic [31:0] rid_ff, rid_in;
   logic [31:0] now_ff, now_in;

   // result being built
   logic        ok_ff, ok_in;
   logic [5:0]  idx_ff, idx_in;
   logic [25:0] offset_ff, offset_in;
   logic [20:0] gsize_ff, gsize_in;
   logic [31:0] aid_ff, aid_in;
   logic [6:0]  freed_ff, freed_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        r_ok_ff, r_ok_in;
   logic [5:0]  r_idx_ff, r_idx_in;
   logic [25:0] r_offset_ff, r_offset_in;
   logic [20:0] r_gsize_ff, r_gsize_in;
   logic [31:0] r_aid_ff, r_aid_in;
   logic [6:0]  r_freed_ff, r_freed_in;
   logic [6:0]  r_used_ff, r_used_in;
   logic [6:0]  r_peak_ff, r_peak_in;
   logic [31:0] r_alloc_ff, r_alloc_in;
   logic [31:0] r_rel_ff, r_rel_in;
   logic [31:0] r_fail_ff, r_fail_in;

   // slot row
   cell_cmd_type           cmd;
   logic [BLOCK_SLOTS-1:0] active;
   logic [BLOCK_SLOTS-1:0] taken_vec;
   logic [BLOCK_SLOTS-1:0] grant_vec;
   logic [BLOCK_SLOTS-1:0] freed_vec;

   logic [6:0]  n_active;
   logic        size_ok;
   logic        any_grant;
   logic [5:0]  grant_idx;
   logic [26:0] offset_prod;
   logic [6:0]  freed_cnt;
   logic [6:0]  used_cnt;
   logic [6:0]  used_now;
   logic [13:0] used_pct;
   logic [13:0] thresh_pct;
   logic [31:0] elapsed;
   logic        rsp_free;

   // active slot count and mask
   always_comb begin
      n_active = (blocks_used_ff > SLOTS_W) ? SLOTS_W : blocks_used_ff;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
         active[i] = 7'(i) < n_active;
      end
   end

   // command to the slot row
   always_comb begin
      cmd.op        = CELL_IDLE;
      cmd.tag       = next_id_ff;
      cmd.match_id  = rid_ff;
      cmd.now       = now_ff;
      cmd.age_limit = max_age_ff;
      size_ok       = size_ff <= block_size_ff;
      if (state_ff == ST_EXEC) begin
         case (op_ff)
            OP_ALLOC:   cmd.op = size_ok ? CELL_CLAIM : CELL_IDLE;
            OP_RELEASE: cmd.op = CELL_FREE;
            OP_SWEEP:   cmd.op = CELL_SWEEP;
            default:    cmd.op = CELL_IDLE;
         endcase
      end else if (state_ff == ST_SWEEP) begin
         cmd.op = CELL_SWEEP;
      end
   end

   fbpa_row #(
      .SLOTS (BLOCK_SLOTS)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .active    (active),
      .taken_vec (taken_vec),
      .grant_vec (grant_vec),
      .freed_vec (freed_vec)
   );

   // row summaries
   always_comb begin
      grant_idx = '0;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
         if (grant_vec[i]) grant_idx = grant_idx | 6'(i);
      end
      any_grant   = |grant_vec;
      offset_prod = 27'(grant_idx) * 27'(block_size_ff);
      freed_cnt   = 7'($countones(freed_vec));
      used_cnt    = 7'($countones(taken_vec & active));
      used_now    = upd_ff ? used_cnt : used_ff;
      used_pct    = 14'(used_now) * PCT_SCALE;
      thresh_pct  = 14'(thresh_ff) * 14'(n_active);
      elapsed     = now_ff - last_sweep_ff;
      rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      used_in       = used_ff;
      peak_in       = peak_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      rel_cnt_in    = rel_cnt_ff;
      fail_cnt_in   = fail_cnt_ff;
      last_sweep_in = last_sweep_ff;
      upd_in        = upd_ff;
      swept_in      = swept_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      rid_in        = rid_ff;
      now_in        = now_ff;
      ok_in         = ok_ff;
      idx_in        = idx_ff;
      offset_in     = offset_ff;
      gsize_in      = gsize_ff;
      aid_in        = aid_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      r_ok_in       = r_ok_ff;
      r_idx_in      = r_idx_ff;
      r_offset_in   = r_offset_ff;
      r_gsize_in    = r_gsize_ff;
      r_aid_in      = r_aid_ff;
      r_freed_in    = r_freed_ff;
      r_used_in     = r_used_ff;
      r_peak_in     = r_peak_ff;
      r_alloc_in    = r_alloc_ff;
      r_rel_in      = r_rel_ff;
      r_fail_in     = r_fail_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               size_in  = req_request_size;
               rid_in   = req_release_id;
               now_in   = req_now_ms;
               state_in = ST_EXEC;
            end
         end

         // row acts on the request; allocation fields settle here
         ST_EXEC: begin
            ok_in     = 1'b0;
            idx_in    = '0;
            offset_in = '0;
            gsize_in  = '0;
            aid_in    = '0;
            freed_in  = '0;
            upd_in    = 1'b0;
            swept_in  = 1'b0;
            case (op_ff)
               OP_ALLOC: begin
                  if (any_grant) begin
                     ok_in        = 1'b1;
                     idx_in       = grant_idx;
                     offset_in    = offset_prod[25:0];
                     gsize_in     = (size_ff != '0) ? size_ff : block_size_ff;
                     aid_in       = next_id_ff;
                     next_id_in   = next_id_ff + 32'd1;
                     alloc_cnt_in = alloc_cnt_ff + 32'd1;
                     upd_in       = 1'b1;
                  end else begin
                     fail_cnt_in = fail_cnt_ff + 32'd1;
                  end
               end
               OP_RELEASE: begin
                  if (any_grant) begin
                     ok_in      = 1'b1;
                     rel_cnt_in = rel_cnt_ff + 32'd1;
                     upd_in     = 1'b1;
                  end
               end
               OP_SWEEP: begin
                  ok_in    = 1'b1;
                  freed_in = freed_cnt;
                  upd_in   = freed_cnt != '0;
               end
               default: begin
               end
            endcase
            state_in = ST_STATS;
         end

         // recount, then the automatic sweep check after an allocate
         ST_STATS: begin
            if (upd_ff) begin
               used_in = used_cnt;
               if (used_cnt > peak_ff) peak_in = used_cnt;
            end
            upd_in   = 1'b0;
            state_in = ST_DONE;
            if (op_ff == OP_ALLOC && !swept_ff && auto_en_ff && elapsed > interval_ff) begin
               last_sweep_in = now_ff;
               if (n_active != '0 && used_pct > thresh_pct) state_in = ST_SWEEP;
            end
         end

         ST_SWEEP: begin
            freed_in = freed_cnt;
            upd_in   = freed_cnt != '0;
            swept_in = 1'b1;
            state_in = ST_STATS;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               r_ok_in      = ok_ff;
               r_idx_in     = idx_ff;
               r_offset_in  = offset_ff;
               r_gsize_in   = gsize_ff;
               r_aid_in     = aid_ff;
               r_freed_in   = freed_ff;
               r_used_in    = used_ff;
               r_peak_in    = peak_ff;
               r_alloc_in   = alloc_cnt_ff;
               r_rel_in     = rel_cnt_ff;
               r_fail_in    = fail_cnt_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // configuration writes
   always_comb begin
      block_size_in  = block_size_ff;
      blocks_used_in = blocks_used_ff;
      max_age_in     = max_age_ff;
      auto_en_in     = auto_en_ff;
      thresh_in      = thresh_ff;
      interval_in    = interval_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_SIZE:  block_size_in  = csr_wr_data[20:0];
            CSR_BLOCKS_USED: blocks_used_in = csr_wr_data[6:0];
            CSR_MAX_AGE:     max_age_in     = csr_wr_data;
            CSR_AUTO_SWEEP:  auto_en_in     = csr_wr_data[0];
            CSR_THRESHOLD:   thresh_in      = csr_wr_data[6:0];
            CSR_INTERVAL:    interval_in    = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_id_ff     <= 32'd1;
         used_ff        <= '0;
         peak_ff        <= '0;
         alloc_cnt_ff   <= '0;
         rel_cnt_ff     <= '0;
         fail_cnt_ff    <= '0;
         last_sweep_ff  <= '0;
         upd_ff         <= 1'b0;
         swept_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         block_size_ff  <= RST_BLOCK_SIZE;
         blocks_used_ff <= RST_BLOCKS_USED;
         max_age_ff     <= RST_MAX_AGE;
         auto_en_ff     <= RST_AUTO_SWEEP;
         thresh_ff      <= RST_THRESHOLD;
         interval_ff    <= RST_INTERVAL;
      end else begin
         state_ff       <= state_in;
         next_id_ff     <= next_id_in;
         used_ff        <= used_in;
         peak_ff        <= peak_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         rel_cnt_ff     <= rel_cnt_in;
         fail_cnt_ff    <= fail_cnt_in;
         last_sweep_ff  <= last_sweep_in;
         upd_ff         <= upd_in;
         swept_ff       <= swept_in;
         rsp_valid_ff   <= rsp_valid_in;
         block_size_ff  <= block_size_in;
         blocks_used_ff <= blocks_used_in;
         max_age_ff     <= max_age_in;
         auto_en_ff     <= auto_en_in;
         thresh_ff      <= thresh_in;
         interval_ff    <= interval_in;
      end
      op_ff       <= op_in;
      size_ff     <= size_in;
      rid_ff      <= rid_in;
      now_ff      <= now_in;
      ok_ff       <= ok_in;
      idx_ff      <= idx_in;
      offset_ff   <= offset_in;
      gsize_ff    <= gsize_in;
      aid_ff      <= aid_in;
      freed_ff    <= freed_in;
      r_ok_ff     <= r_ok_in;
      r_idx_ff    <= r_idx_in;
      r_offset_ff <= r_offset_in;
      r_gsize_ff  <= r_gsize_in;
      r_aid_ff    <= r_aid_in;
      r_freed_ff  <= r_freed_in;
      r_used_ff   <= r_used_in;
      r_peak_ff   <= r_peak_in;
      r_alloc_ff  <= r_alloc_in;
      r_rel_ff    <= r_rel_in;
      r_fail_ff   <= r_fail_in;
   end

   assign req_ready            = state_ff == ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ok               = r_ok_ff;
   assign rsp_block_index      = r_idx_ff;
   assign rsp_buffer_offset    = r_offset_ff;
   assign rsp_granted_size     = r_gsize_ff;
   assign rsp_allocation_id    = r_aid_ff;
   assign rsp_blocks_freed     = r_freed_ff;
   assign rsp_used_blocks      = r_used_ff;
   assign rsp_peak_used        = r_peak_ff;
   assign rsp_allocation_total = r_alloc_ff;
   assign rsp_release_total    = r_rel_ff;
   assign rsp_failure_total    = r_fail_ff;

endmodule

/* rtl/fbpa_cell.sv */
module fbpa_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  fbpa_pkg::cell_cmd_type cmd,
   input  logic                   active,
   input  logic                   busy_in,
   output logic                   busy_out,
   output fbpa_pkg::cell_stat_type stat
);
   import fbpa_pkg::*;

   logic        taken_ff, taken_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] time_ff, time_in;
   logic        hit;
   logic        grant;
   logic        aged;
   logic [31:0] age;

   // candidate for claim (free slot) or release (matching ID)
   always_comb begin
      age  = cmd.now - time_ff;
      aged = active && taken_ff && (age > cmd.age_limit);
      case (cmd.op)
         CELL_CLAIM: hit = active && !taken_ff;
         CELL_FREE:  hit = active && taken_ff && (id_ff == cmd.match_id);
         default:    hit = 1'b0;
      endcase
      grant    = hit && !busy_in;
      busy_out = busy_in || hit;
   end

   // slot update
   always_comb begin
      taken_in = taken_ff;
      id_in    = id_ff;
      time_in  = time_ff;
      case (cmd.op)
         CELL_CLAIM: begin
            if (grant) begin
               taken_in = 1'b1;
               id_in    = cmd.tag;
               time_in  = cmd.now;
            end
         end
         CELL_FREE: begin
            if (grant) taken_in = 1'b0;
         end
         CELL_SWEEP: begin
            if (aged) taken_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= 1'b0;
      end else begin
         taken_ff <= taken_in;
      end
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   assign stat.taken = taken_ff;
   assign stat.grant = grant;
   assign stat.freed = (cmd.op == CELL_SWEEP) && aged;

endmodule

/* rtl/fbpa_row.sv */
module fbpa_row #(
   parameter int SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fbpa_pkg::cell_cmd_type cmd,
   input  logic [SLOTS-1:0]       active,
   output logic [SLOTS-1:0]       taken_vec,
   output logic [SLOTS-1:0]       grant_vec,
   output logic [SLOTS-1:0]       freed_vec
);
   import fbpa_pkg::*;

   // busy ripples from slot 0 upward so the lowest candidate wins
   logic [SLOTS:0] busy;
   cell_stat_type  stat [SLOTS];

   assign busy[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      fbpa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .active   (active[i]),
         .busy_in  (busy[i]),
         .busy_out (busy[i+1]),
         .stat     (stat[i])
      );
      assign taken_vec[i] = stat[i].taken;
      assign grant_vec[i] = stat[i].grant;
      assign freed_vec[i] = stat[i].freed;
   end

endmodule
